// File: rtl/core/pmfwrl_pkg.sv
`default_nettype none
package pmfwrl_pkg;

  localparam int unsigned BUCKETS  = 4096;
  localparam int unsigned BKT_W    = $clog2(BUCKETS);
  localparam int unsigned WAYS_DEF = 4;
  localparam int unsigned CFG_W    = 36;
  localparam int unsigned CFG_AW   = 3;

  localparam logic [CFG_AW-1:0] CFG_ENABLE   = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_DHCP_MAC = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_DHCP_GLB = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_ARP_MAC  = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_WINDOW   = 3'd4;

  localparam logic        RST_ENABLE   = 1'b1;
  localparam logic [15:0] RST_DHCP_MAC = 16'd10;
  localparam logic [23:0] RST_DHCP_GLB = 24'd50000;
  localparam logic [15:0] RST_ARP_MAC  = 16'd100;
  localparam logic [35:0] RST_WINDOW   = 36'd1000000000;

  localparam logic KIND_DHCP = 1'b0;

  typedef enum logic [2:0] {
    RSN_COUNTED  = 3'd0,
    RSN_DISABLED = 3'd1,
    RSN_FULL     = 3'd2,
    RSN_GLOBAL   = 3'd3,
    RSN_MAC_DHCP = 3'd4,
    RSN_MAC_ARP  = 3'd5
  } reason_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } dp_status_t;

  typedef struct packed {
    logic        valid;
    logic [47:0] mac;
    logic [63:0] start;
    logic [15:0] dcnt;
    logic [15:0] acnt;
  } entry_t;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [47:0] mac);
    logic [7:0] h;
    h = mac[7:0] ^ mac[15:8] ^ mac[23:16] ^ mac[31:24] ^ mac[39:32] ^ mac[47:40];
    return BKT_W'(h);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/pmfwrl_ctrl.sv
`default_nettype none
module pmfwrl_ctrl
  import pmfwrl_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_CLEAR:  cmd_o.clr_wr = 1'b1;
      ST_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.capture = start_i;
      end
      ST_DECIDE: cmd_o.commit = 1'b1;
      default:   busy_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/pmfwrl_datapath.sv
`default_nettype none
module pmfwrl_datapath
  import pmfwrl_pkg::*;
#(
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  wire                cfg_we_i,
  input  wire  [CFG_AW-1:0]  cfg_addr_i,
  input  wire  [CFG_W-1:0]   cfg_wdata_i,
  input  wire                kind_i,
  input  wire  [47:0]        src_mac_i,
  input  wire  [63:0]        now_ns_i,
  output logic               done_o,
  output logic               allow_o,
  output logic [2:0]         verdict_reason_o,
  output logic [31:0]        dhcp_drop_total_o,
  output logic [31:0]        arp_drop_total_o
);

  localparam int unsigned WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

  // config registers
  logic        en_q;
  logic [15:0] lim_dm_q;
  logic [23:0] lim_dg_q;
  logic [15:0] lim_am_q;
  logic [35:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= RST_ENABLE;
      lim_dm_q <= RST_DHCP_MAC;
      lim_dg_q <= RST_DHCP_GLB;
      lim_am_q <= RST_ARP_MAC;
      win_q    <= RST_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_ENABLE:   en_q     <= cfg_wdata_i[0];
        CFG_DHCP_MAC: lim_dm_q <= cfg_wdata_i[15:0];
        CFG_DHCP_GLB: lim_dg_q <= cfg_wdata_i[23:0];
        CFG_ARP_MAC:  lim_am_q <= cfg_wdata_i[15:0];
        CFG_WINDOW:   win_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clearing pass counter
  logic [BKT_W-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + 1'b1;
    end
  end
  assign status_o.clr_last = &clr_q;

  // captured transaction
  logic             kind_q;
  logic [47:0]      mac_q;
  logic [63:0]      now_q;
  logic [BKT_W-1:0] bkt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      mac_q  <= src_mac_i;
      now_q  <= now_ns_i;
      bkt_q  <= bucket_of(src_mac_i);
    end
  end

  // bucket row memory
  entry_t [WAYS-1:0] mem [BUCKETS];
  entry_t [WAYS-1:0] row_q;
  entry_t [WAYS-1:0] row_new;
  logic              tbl_we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= mem[bucket_of(src_mac_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[clr_q] <= '0;
    end else if (cmd_i.commit && tbl_we) begin
      mem[bkt_q] <= row_new;
    end
  end

  // global state
  logic [23:0] gcnt_q, gcnt_d;
  logic [63:0] gstart_q, gstart_d;
  logic [31:0] ddrop_q, ddrop_d;
  logic [31:0] adrop_q, adrop_d;
  logic        done_q;
  logic        allow_q, allow_d;
  reason_e     rsn_q, rsn_d;

  // lookup
  logic [WAYS-1:0]  hit, free;
  logic [WAY_W-1:0] hit_idx, free_idx, idx;
  logic             slot_ok;
  entry_t           cur, upd;
  logic             ent_exp, mac_drop;
  logic             gexp, gdrop;
  logic [23:0]      gcnt_e;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      hit[w]  = row_q[w].valid && (row_q[w].mac == mac_q);
      free[w] = !row_q[w].valid;
      if (hit[w])  hit_idx  = WAY_W'(w);
      if (free[w]) free_idx = WAY_W'(w);
    end
  end

  always_comb begin
    slot_ok = (|hit) || (|free);
    idx     = (|hit) ? hit_idx : free_idx;
    if (|hit) begin
      cur = row_q[idx];
    end else begin
      cur       = '0;
      cur.valid = 1'b1;
      cur.mac   = mac_q;
      cur.start = now_q;
    end
    ent_exp = (now_q - cur.start) > {28'd0, win_q};
    upd     = cur;
    if (kind_q == KIND_DHCP) begin
      if (ent_exp) begin
        upd.dcnt  = '0;
        upd.start = now_q;
      end
      mac_drop = upd.dcnt >= lim_dm_q;
      if (!mac_drop) upd.dcnt = upd.dcnt + 16'd1;
    end else begin
      if (ent_exp) begin
        upd.acnt  = '0;
        upd.start = now_q;
      end
      mac_drop = upd.acnt >= lim_am_q;
      if (!mac_drop) upd.acnt = upd.acnt + 16'd1;
    end
    row_new      = row_q;
    row_new[idx] = upd;
  end

  always_comb begin
    gexp   = (now_q - gstart_q) > {28'd0, win_q};
    gcnt_e = gexp ? 24'd0 : gcnt_q;
    gdrop  = gcnt_e >= lim_dg_q;

    gcnt_d   = gcnt_q;
    gstart_d = gstart_q;
    ddrop_d  = ddrop_q;
    adrop_d  = adrop_q;
    allow_d  = 1'b1;
    rsn_d    = RSN_COUNTED;
    tbl_we   = 1'b0;

    if (!en_q) begin
      rsn_d = RSN_DISABLED;
    end else if (kind_q == KIND_DHCP) begin
      gcnt_d   = gcnt_e;
      gstart_d = gexp ? now_q : gstart_q;
      if (gdrop) begin
        allow_d = 1'b0;
        rsn_d   = RSN_GLOBAL;
        ddrop_d = ddrop_q + 32'd1;
      end else if (!slot_ok) begin
        rsn_d = RSN_FULL;
      end else begin
        tbl_we = 1'b1;
        if (mac_drop) begin
          allow_d = 1'b0;
          rsn_d   = RSN_MAC_DHCP;
          ddrop_d = ddrop_q + 32'd1;
        end else begin
          gcnt_d = gcnt_e + 24'd1;
        end
      end
    end else begin
      if (!slot_ok) begin
        rsn_d = RSN_FULL;
      end else begin
        tbl_we = 1'b1;
        if (mac_drop) begin
          allow_d = 1'b0;
          rsn_d   = RSN_MAC_ARP;
          adrop_d = adrop_q + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcnt_q   <= '0;
      gstart_q <= '0;
      ddrop_q  <= '0;
      adrop_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        gcnt_q   <= gcnt_d;
        gstart_q <= gstart_d;
        ddrop_q  <= ddrop_d;
        adrop_q  <= adrop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      allow_q <= allow_d;
      rsn_q   <= rsn_d;
    end
  end

  assign done_o            = done_q;
  assign allow_o           = allow_q;
  assign verdict_reason_o  = rsn_q;
  assign dhcp_drop_total_o = ddrop_q;
  assign arp_drop_total_o  = adrop_q;

endmodule
`default_nettype wire

// File: rtl/core/per_mac_fixed_window_rate_limiter_unit.sv
`default_nettype none
// Per-MAC fixed-window DHCP/ARP rate limiter. After reset the block runs a
// clearing pass over the 4096-row bucket memory and holds busy_o high until
// the pass ends; configuration writes are taken during that time. A
// transaction is accepted when start_i is high and busy_o is low. Its
// verdict is registered on the result ports with done_o, a one-cycle strobe,
// at the end of the DECIDE state that follows acceptance. busy_o stays high
// in DECIDE, so no new transaction is taken until the read-modify-write of
// its bucket row in the single-port table memory is done. The receiver cannot stall results.
module per_mac_fixed_window_rate_limiter_unit
  import pmfwrl_pkg::*;
#(
  parameter int unsigned WAYS = WAYS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [CFG_AW-1:0] cfg_addr_i,
  input  wire  [CFG_W-1:0]  cfg_wdata_i,
  input  wire               start_i,
  output logic              busy_o,
  input  wire               kind_i,
  input  wire  [47:0]       src_mac_i,
  input  wire  [63:0]       now_ns_i,
  output logic              done_o,
  output logic              allow_o,
  output logic [2:0]        verdict_reason_o,
  output logic [31:0]       dhcp_drop_total_o,
  output logic [31:0]       arp_drop_total_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pmfwrl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  pmfwrl_datapath #(
    .WAYS (WAYS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_addr_i        (cfg_addr_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .kind_i            (kind_i),
    .src_mac_i         (src_mac_i),
    .now_ns_i          (now_ns_i),
    .done_o            (done_o),
    .allow_o           (allow_o),
    .verdict_reason_o  (verdict_reason_o),
    .dhcp_drop_total_o (dhcp_drop_total_o),
    .arp_drop_total_o  (arp_drop_total_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/pmfwrl_checker.sv
`default_nettype none
module pmfwrl_checker
  import pmfwrl_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              start_i,
  input wire              busy_o,
  input wire              done_o,
  input wire              allow_o,
  input wire [2:0]        verdict_reason_o,
  input wire [31:0]       dhcp_drop_total_o,
  input wire [31:0]       arp_drop_total_o
);

  // every accepted transaction later gets its verdict on done_o
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("missing verdict");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("verdict strobe too long");

  // a drop always carries a limit reason
  a_drop_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !allow_o) |-> (verdict_reason_o == RSN_GLOBAL ||
      verdict_reason_o == RSN_MAC_DHCP || verdict_reason_o == RSN_MAC_ARP))
    else $error("drop with pass reason");

  a_drop_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!done_o && $past(rst_ni)) |-> ($stable(dhcp_drop_total_o) && $stable(arp_drop_total_o)))
    else $error("drop totals moved without a verdict");

endmodule

bind per_mac_fixed_window_rate_limiter_unit pmfwrl_checker u_pmfwrl_checker (.*);
`default_nettype wire

// File: test/tb_top.sv
module tb_top;
  import pmfwrl_pkg::*;

  localparam int unsigned SLOTS = BUCKETS * WAYS_DEF;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct {
    bit      allow;
    reason_e rsn;
    bit [31:0] dhcp_drops;
    bit [31:0] arp_drops;
  } verdict_t;

  class limiter_scoreboard;
    bit        en;
    bit [15:0] dhcp_mac_lim;
    bit [23:0] dhcp_glb_lim;
    bit [15:0] arp_mac_lim;
    bit [35:0] win_len;
    bit        slot_vld[SLOTS];
    bit [47:0] slot_mac[SLOTS];
    bit [63:0] slot_start[SLOTS];
    bit [15:0] slot_dcnt[SLOTS];
    bit [15:0] slot_acnt[SLOTS];
    bit [23:0] glb_cnt;
    bit [63:0] glb_start;
    bit [31:0] dhcp_drops;
    bit [31:0] arp_drops;
    verdict_t  pending[$];
    int        fails;

    function new();
      en = RST_ENABLE;
      dhcp_mac_lim = RST_DHCP_MAC;
      dhcp_glb_lim = RST_DHCP_GLB;
      arp_mac_lim = RST_ARP_MAC;
      win_len = RST_WINDOW;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] idx, bit [CFG_W-1:0] val);
      case (idx)
        CFG_ENABLE:   en = val[0];
        CFG_DHCP_MAC: dhcp_mac_lim = val[15:0];
        CFG_DHCP_GLB: dhcp_glb_lim = val[23:0];
        CFG_ARP_MAC:  arp_mac_lim = val[15:0];
        CFG_WINDOW:   win_len = val[35:0];
        default: ;
      endcase
    endfunction

    function bit expired(bit [63:0] now, bit [63:0] since);
      bit [63:0] span;
      span = now - since;
      return span > {28'd0, win_len};
    endfunction

    function int find_slot(bit [47:0] mac, bit [63:0] now);
      bit [7:0] h;
      int base;
      int free_slot;
      h = mac[7:0] ^ mac[15:8] ^ mac[23:16] ^ mac[31:24] ^ mac[39:32] ^ mac[47:40];
      base = int'(h) * int'(WAYS_DEF);
      free_slot = -1;
      for (int w = 0; w < WAYS_DEF; w++) begin
        if (slot_vld[base+w]) begin
          if (slot_mac[base+w] == mac) return base + w;
        end else if (free_slot < 0) begin
          free_slot = base + w;
        end
      end
      if (free_slot >= 0) begin
        slot_vld[free_slot] = 1;
        slot_mac[free_slot] = mac;
        slot_start[free_slot] = now;
        slot_dcnt[free_slot] = 0;
        slot_acnt[free_slot] = 0;
      end
      return free_slot;
    endfunction

    function void note_packet(bit kind, bit [47:0] mac, bit [63:0] now);
      verdict_t v;
      int s;
      v.allow = 1;
      v.rsn = RSN_COUNTED;
      if (!en) begin
        v.rsn = RSN_DISABLED;
      end else if (kind == KIND_DHCP) begin
        if (expired(now, glb_start)) begin
          glb_cnt = 0;
          glb_start = now;
        end
        if (glb_cnt >= dhcp_glb_lim) begin
          v.allow = 0;
          v.rsn = RSN_GLOBAL;
          dhcp_drops++;
        end else begin
          s = find_slot(mac, now);
          if (s < 0) begin
            v.rsn = RSN_FULL;
          end else begin
            if (expired(now, slot_start[s])) begin
              slot_dcnt[s] = 0;
              slot_start[s] = now;
            end
            if (slot_dcnt[s] >= dhcp_mac_lim) begin
              v.allow = 0;
              v.rsn = RSN_MAC_DHCP;
              dhcp_drops++;
            end else begin
              slot_dcnt[s]++;
              glb_cnt++;
            end
          end
        end
      end else begin
        s = find_slot(mac, now);
        if (s < 0) begin
          v.rsn = RSN_FULL;
        end else begin
          if (expired(now, slot_start[s])) begin
            slot_acnt[s] = 0;
            slot_start[s] = now;
          end
          if (slot_acnt[s] >= arp_mac_lim) begin
            v.allow = 0;
            v.rsn = RSN_MAC_ARP;
            arp_drops++;
          end else begin
            slot_acnt[s]++;
          end
        end
      end
      v.dhcp_drops = dhcp_drops;
      v.arp_drops = arp_drops;
      pending.push_back(v);
    endfunction

    function void check_verdict(logic allow, logic [2:0] rsn, logic [31:0] dd,
                                logic [31:0] ad);
      verdict_t v;
      if (pending.size() == 0) begin
        if (fails < 10) $display("unexpected verdict: allow %0b reason %0d", allow, rsn);
        fails++;
        return;
      end
      v = pending.pop_front();
      if (allow !== v.allow || rsn !== v.rsn || dd !== v.dhcp_drops ||
          ad !== v.arp_drops) begin
        if (fails < 10)
          $display("mismatch: exp allow %0b reason %0d dd %0d ad %0d, got %0b %0d %0d %0d",
                   v.allow, v.rsn, v.dhcp_drops, v.arp_drops, allow, rsn, dd, ad);
        fails++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_AW-1:0] cfg_addr_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              start_i;
  logic              busy_o;
  logic              kind_i;
  logic [47:0]       src_mac_i;
  logic [63:0]       now_ns_i;
  logic              done_o;
  logic              allow_o;
  logic [2:0]        verdict_reason_o;
  logic [31:0]       dhcp_drop_total_o;
  logic [31:0]       arp_drop_total_o;

  limiter_scoreboard sb = new();
  int  stall_cycles;
  bit  no_gaps;
  bit [63:0] clock_ns;
  bit [47:0] mac_pool[12];

  per_mac_fixed_window_rate_limiter_unit i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_addr_i, .cfg_wdata_i, .start_i, .busy_o,
    .kind_i, .src_mac_i, .now_ns_i, .done_o, .allow_o, .verdict_reason_o,
    .dhcp_drop_total_o, .arp_drop_total_o
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (done_o) sb.check_verdict(allow_o, verdict_reason_o, dhcp_drop_total_o,
                                 arp_drop_total_o);
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_packet(bit kind, bit [47:0] mac, bit [63:0] now);
    int gap;
    gap = no_gaps ? 0 : int'($urandom_range(0, 7));
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i <= kind;
    src_mac_i <= mac;
    now_ns_i <= now;
    start_i <= 1;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_packet(kind, mac, now);
  endtask

  task automatic settle();
    @(negedge clk_i);
    start_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [CFG_AW-1:0] idx, bit [CFG_W-1:0] val);
    settle();
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, val);
  endtask

  // mac whose bytes xor to the given bucket
  function automatic bit [47:0] mac_in_bucket(bit [7:0] bkt);
    bit [47:0] m;
    m = 48'({$urandom, $urandom});
    m[7:0] = m[15:8] ^ m[23:16] ^ m[31:24] ^ m[39:32] ^ m[47:40] ^ bkt;
    return m;
  endfunction

  task automatic random_phase(int n);
    bit [7:0] b0;
    bit [7:0] b1;
    bit [47:0] mac;
    b0 = 8'($urandom);
    b1 = 8'($urandom);
    foreach (mac_pool[i])
      mac_pool[i] = mac_in_bucket(i < 5 ? b0 : (i < 9 ? b1 : 8'($urandom)));
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && $urandom_range(0, 1)) settle();
      if ($urandom_range(0, 40) == 0) clock_ns = {$urandom, $urandom};
      else clock_ns += 64'($urandom_range(0, 60));
      mac = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) :
            mac_pool[$urandom_range(0, 11)];
      send_packet(1'($urandom_range(0, 1)), mac, clock_ns);
    end
  endtask

  initial begin
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_addr_i = CFG_ENABLE;
    cfg_wdata_i = '0;
    start_i = 0;
    kind_i = 0;
    src_mac_i = '0;
    now_ns_i = '0;
    stall_cycles = 0;
    no_gaps = 0;
    clock_ns = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // defaults, extremes of fields
    send_packet(KIND_DHCP, 48'h0, 64'h0);
    send_packet(1'b1, 48'hFFFF_FFFF_FFFF, 64'h0);
    send_packet(KIND_DHCP, 48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // per-mac dhcp limit and lowered limit
    write_cfg(CFG_DHCP_MAC, 36'd2);
    for (int i = 0; i < 3; i++) send_packet(KIND_DHCP, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    // arp limit of zero
    write_cfg(CFG_ARP_MAC, 36'd0);
    send_packet(1'b1, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CFG_ARP_MAC, 36'hFFFF);
    // bucket full
    for (int i = 1; i <= 5; i++) send_packet(1'b1, (48'h0101 * 48'(i)) << 8, 64'd5);
    // global limit
    write_cfg(CFG_DHCP_GLB, 36'd3);
    send_packet(KIND_DHCP, 48'h0A0B_0C0D_0E0F, 64'hFFFF_FFFF_FFFF_FFFF);
    send_packet(KIND_DHCP, 48'h1112_1314_1516, 64'hFFFF_FFFF_FFFF_FFFF);
    // minimal window, expiry and time going backwards
    write_cfg(CFG_WINDOW, 36'd1);
    send_packet(KIND_DHCP, 48'h0, 64'd100);
    send_packet(KIND_DHCP, 48'h0, 64'd101);
    send_packet(KIND_DHCP, 48'h0, 64'd103);
    send_packet(1'b1, 48'h0, 64'd2);
    // disabled
    write_cfg(CFG_ENABLE, 36'd0);
    send_packet(KIND_DHCP, 48'h0, 64'd3);
    send_packet(1'b1, 48'h0, 64'd3);
    write_cfg(CFG_ENABLE, 36'd1);
    write_cfg(CFG_WINDOW, 36'hF_FFFF_FFFF);
    write_cfg(CFG_DHCP_GLB, 36'hFF_FFFF);
    write_cfg(CFG_DHCP_MAC, 36'hFFFF);
    send_packet(KIND_DHCP, 48'h5555_AAAA_5555, 64'd4);

    for (int p = 0; p < 9; p++) begin
      write_cfg(CFG_ENABLE, CFG_W'($urandom_range(0, 7) != 0));
      write_cfg(CFG_DHCP_MAC, CFG_W'((p == 3) ? 32'hFFFF : $urandom_range(0, 8)));
      write_cfg(CFG_ARP_MAC, CFG_W'((p == 4) ? 32'hFFFF : $urandom_range(0, 8)));
      write_cfg(CFG_DHCP_GLB, CFG_W'((p == 5) ? 32'hFF_FFFF : $urandom_range(0, 30)));
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_WINDOW, 36'd1);
        1: write_cfg(CFG_WINDOW, 36'hF_FFFF_FFFF);
        default: write_cfg(CFG_WINDOW, CFG_W'($urandom_range(10, 300)));
      endcase
      no_gaps = (p % 3 == 1);
      random_phase(205);
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pmfwrl_pkg.sv
rtl/core/pmfwrl_ctrl.sv
rtl/core/pmfwrl_datapath.sv
rtl/core/per_mac_fixed_window_rate_limiter_unit.sv
rtl/core/pmfwrl_checker.sv
test/tb_top.sv
